>>> design/srd_pkg.sv
// Types and constants shared by the saturating restoring divider.
`default_nettype none

package srd_pkg;

   localparam int DIVIDEND_WIDTH = 63;
   localparam int DIVISOR_WIDTH  = 31;
   localparam int QUOTIENT_WIDTH = 31;
   localparam int NUM_STEPS      = QUOTIENT_WIDTH;
   localparam int SDIV_WIDTH     = DIVISOR_WIDTH + NUM_STEPS;

   localparam logic [QUOTIENT_WIDTH-1:0] QUOTIENT_MAX = {QUOTIENT_WIDTH{1'b1}};

   typedef struct packed {
      logic [DIVIDEND_WIDTH-1:0] dividend;
      logic [DIVISOR_WIDTH-1:0]  divisor;
   } srd_req_type;

   typedef struct packed {
      logic [QUOTIENT_WIDTH-1:0] quotient;
      logic [DIVISOR_WIDTH-1:0]  remainder;
      logic                      saturated;
   } srd_rsp_type;

   // The shifted divisor holds the divisor one place further left than the
   // step that reads it, so that no bit is lost before the final check.
   typedef struct packed {
      logic [DIVIDEND_WIDTH-1:0] part;
      logic [SDIV_WIDTH-1:0]     sdiv;
      logic [QUOTIENT_WIDTH-1:0] quo;
   } srd_stage_type;

endpackage

`default_nettype wire

>>> design/srd_step.sv
// One pipeline stage of the divider: a single compare-and-subtract step.
`default_nettype none

module srd_step
   import srd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire srd_stage_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output srd_stage_type      out_data
);

   logic                      valid_ff;
   logic                      valid_in;
   srd_stage_type             data_ff;
   srd_stage_type             data_in;
   logic [DIVIDEND_WIDTH-1:0] cmp;
   logic [DIVIDEND_WIDTH-1:0] diff;
   logic                      fits;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      cmp  = {{(DIVIDEND_WIDTH-SDIV_WIDTH+1){1'b0}}, in_data.sdiv[SDIV_WIDTH-1:1]};
      fits = in_data.part >= cmp;
      diff = in_data.part - cmp;
      data_in.part = fits ? diff : in_data.part;
      data_in.sdiv = {1'b0, in_data.sdiv[SDIV_WIDTH-1:1]};
      data_in.quo  = {in_data.quo[QUOTIENT_WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> design/srd_final.sv
// Output stage of the divider: overflow check, saturation and result register.
`default_nettype none

module srd_final
   import srd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire srd_stage_type in_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output srd_rsp_type        rsp_data
);

   logic                      valid_ff;
   logic                      valid_in;
   srd_rsp_type               data_ff;
   srd_rsp_type               data_in;
   logic [DIVISOR_WIDTH-1:0]  dvs;
   logic                      over;

   assign in_ready = !valid_ff || rsp_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      dvs  = in_data.sdiv[DIVISOR_WIDTH-1:0];
      over = in_data.part >= {{(DIVIDEND_WIDTH-DIVISOR_WIDTH){1'b0}}, dvs};
      if (over) begin
         data_in.quotient  = QUOTIENT_MAX;
         data_in.remainder = '0;
         data_in.saturated = 1'b1;
      end else begin
         data_in.quotient  = in_data.quo;
         data_in.remainder = in_data.part[DIVISOR_WIDTH-1:0];
         data_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

>>> design/saturating_restoring_divider_top.sv
// A request transfer passes through 31 compare-and-subtract stages, one per quotient bit, and
// then through the overflow check and output stage; every stage registers its result.
// Throughput: one transfer per cycle while the output does not stall; each stage holds its item only
// while its successor stalls, so empty stages keep accepting while a result waits at the output.
// Reset clears the valid bit of every stage; data registers are not reset.
`default_nettype none

module saturating_restoring_divider_top
   import srd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire srd_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output srd_rsp_type      rsp_data
);

   logic          stage_valid [0:NUM_STEPS];
   logic          stage_ready [0:NUM_STEPS];
   srd_stage_type stage_data  [0:NUM_STEPS];

   assign stage_valid[0]     = req_valid;
   assign req_ready          = stage_ready[0];
   assign stage_data[0].part = req_data.dividend;
   assign stage_data[0].sdiv = {req_data.divisor, {NUM_STEPS{1'b0}}};
   assign stage_data[0].quo  = '0;

   for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
      srd_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   srd_final u_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[NUM_STEPS]),
      .in_ready  (stage_ready[NUM_STEPS]),
      .in_data   (stage_data[NUM_STEPS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> tb/sv/srd_result_checker.sv
// Watches both channels of the divider, predicts each quotient and checks every result.
module srd_result_checker
   import srd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire srd_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire srd_rsp_type rsp_data,
   output int               mismatches,
   output int               owed
);

   timeunit 1ns;
   timeprecision 1ps;

   srd_rsp_type owed_divisions[$];

   function automatic srd_rsp_type divide_restoring(srd_req_type item);
      logic [63:0]               part;
      logic [63:0]               step_div;
      logic [QUOTIENT_WIDTH-1:0] quo;
      srd_rsp_type               res;
      part = {1'b0, item.dividend};
      quo  = '0;
      for (int k = QUOTIENT_WIDTH - 1; k >= 0; k--) begin
         step_div = 64'(item.divisor) << k;
         if (part >= step_div) begin
            part   = part - step_div;
            quo[k] = 1'b1;
         end
      end
      if (part >= 64'(item.divisor)) begin
         res.quotient  = QUOTIENT_MAX;
         res.remainder = '0;
         res.saturated = 1'b1;
      end else begin
         res.quotient  = quo;
         res.remainder = part[DIVISOR_WIDTH-1:0];
         res.saturated = 1'b0;
      end
      return res;
   endfunction

   initial begin
      mismatches = 0;
      owed       = 0;
   end

   always @(posedge clock) begin
      srd_rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (owed_divisions.size() == 0) begin
               $error("result transfer with no division outstanding: %h", rsp_data);
               mismatches++;
            end else begin
               want = owed_divisions.pop_front();
               if (rsp_data.quotient !== want.quotient) begin
                  $error("quotient: expected %h, got %h", want.quotient, rsp_data.quotient);
                  mismatches++;
               end
               if (rsp_data.remainder !== want.remainder) begin
                  $error("remainder: expected %h, got %h", want.remainder, rsp_data.remainder);
                  mismatches++;
               end
               if (rsp_data.saturated !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, rsp_data.saturated);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            owed_divisions.push_back(divide_restoring(req_data));
         end
      end
      owed <= owed_divisions.size();
   end

endmodule

>>> tb/sv/tb.sv
// Top of the divider testbench: clock, reset, stimulus, receiver stalls and the verdict.
module tb
   import srd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [DIVISOR_WIDTH-1:0]  DIVISOR_MAX  = {DIVISOR_WIDTH{1'b1}};
   localparam logic [DIVIDEND_WIDTH-1:0] DIVIDEND_MAX = {DIVIDEND_WIDTH{1'b1}};
   localparam int ITEMS_PER_PHASE = 150;
   localparam int HOLD_CYCLES     = 300;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   srd_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   srd_rsp_type rsp_data;

   int mismatches;
   int owed;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   bit hold_go      = 1'b0;
   bit hold_done    = 1'b0;

   int tx_idle_by_phase[4]  = '{0, 77, 0, 35};
   int rx_stall_by_phase[4] = '{0, 0, 77, 35};

   saturating_restoring_divider_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   srd_result_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .owed       (owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] random_bits(int width);
      logic [63:0] v;
      v = {$urandom, $urandom};
      return (width >= 64) ? v : v & ((64'd1 << width) - 64'd1);
   endfunction

   // Mostly exact divisions with a random remainder, then saturating cases, the
   // boundary of the largest quotient, zero divisors and wholly random operands.
   function automatic srd_req_type random_division();
      int          kind;
      logic [63:0] dvs;
      logic [63:0] quo;
      logic [63:0] num;
      srd_req_type item;
      kind = $urandom_range(99);
      dvs  = random_bits($urandom_range(1, DIVISOR_WIDTH));
      if (kind < 60) begin
         if (dvs == 0) begin
            dvs = 64'd1;
         end
         quo = random_bits($urandom_range(0, QUOTIENT_WIDTH));
         num = quo * dvs + random_bits(64) % dvs;
      end else if (kind < 75) begin
         num = random_bits(DIVIDEND_WIDTH) | (dvs << QUOTIENT_WIDTH);
      end else if (kind < 85) begin
         if (dvs == 0) begin
            dvs = 64'd1;
         end
         num = (dvs << QUOTIENT_WIDTH) - 64'($urandom_range(0, 1));
      end else if (kind < 92) begin
         dvs = 64'd0;
         num = random_bits($urandom_range(1, DIVIDEND_WIDTH));
      end else begin
         dvs = random_bits(DIVISOR_WIDTH);
         num = random_bits($urandom_range(1, DIVIDEND_WIDTH));
      end
      item.dividend = num[DIVIDEND_WIDTH-1:0];
      item.divisor  = dvs[DIVISOR_WIDTH-1:0];
      return item;
   endfunction

   task automatic send_division(input srd_req_type item);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) begin
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_division('{dividend: '0, divisor: 31'd1});
      send_division('{dividend: '0, divisor: '0});
      send_division('{dividend: DIVIDEND_MAX, divisor: '0});
      send_division('{dividend: DIVIDEND_MAX, divisor: DIVISOR_MAX});
      send_division('{dividend: DIVIDEND_MAX, divisor: 31'd1});
      send_division('{dividend: '0, divisor: DIVISOR_MAX});
      send_division('{dividend: 63'({DIVISOR_MAX, 31'd0}) - 63'd1, divisor: DIVISOR_MAX});
      send_division('{dividend: 63'({DIVISOR_MAX, 31'd0}), divisor: DIVISOR_MAX});
      send_division('{dividend: 63'h7FFF_FFFF, divisor: 31'd1});
      send_division('{dividend: 63'h8000_0000, divisor: 31'd1});
      send_division('{dividend: 63'd12345, divisor: 31'd12345});
      send_division('{dividend: 63'd12344, divisor: 31'd12345});
      send_division('{dividend: 63'h5555_5555_5555_5555, divisor: 31'h2AAA_AAAA});
      send_division('{dividend: 63'h2AAA_AAAA_AAAA_AAAA, divisor: 31'h5555_5555});
      send_division('{dividend: 63'h2AAA_AAAA_AAAA_AAAA, divisor: 31'h4000_0000});
      send_division('{dividend: 63'h1555_5555_5555_5555, divisor: 31'h2AAA_AAAB});

      for (int phase = 0; phase < 4; phase++) begin
         tx_idle_pct = tx_idle_by_phase[phase];
         rx_stall_pct <= rx_stall_by_phase[phase];
         if (phase == 0) begin
            hold_go <= 1'b1;
         end
         repeat (ITEMS_PER_PHASE) begin
            send_division(random_division());
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (owed != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
design/srd_pkg.sv
design/srd_step.sv
design/srd_final.sv
design/saturating_restoring_divider_top.sv
tb/sv/srd_result_checker.sv
tb/sv/tb.sv
